>>> src/wenc_pkg.sv
// Shared types and constants of the wall erosion block.
`default_nettype none
package wenc_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SKIP  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ROWS    = 3'd0;
    localparam logic [2:0] CFG_COLS    = 3'd1;
    localparam logic [2:0] CFG_PASSES  = 3'd2;
    localparam logic [2:0] CFG_BOUND_A = 3'd3;
    localparam logic [2:0] CFG_BOUND_B = 3'd4;

    // Tile bytes and counter limits.
    localparam logic [7:0]  WALL_BYTE  = 8'h23;
    localparam logic [7:0]  FLOOR_BYTE = 8'h2E;
    localparam logic [14:0] OPENED_MAX = 15'h7FFF;
    localparam logic [3:0]  NB_LAST    = 4'd8;

    typedef logic [14:0] opened_t;

endpackage
`default_nettype wire

>>> src/wenc_req_if.sv
// Request channel interface of the wall erosion block.
`default_nettype none
interface wenc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [6:0] row;
    logic [6:0] col;
    logic [7:0] tile_in;

    modport source (output valid, kind, row, col, tile_in, input ready);
    modport sink (input valid, kind, row, col, tile_in, output ready);
endinterface
`default_nettype wire

>>> src/wenc_rsp_if.sv
// Result channel interface of the wall erosion block.
`default_nettype none
interface wenc_rsp_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           tile_out;
    wenc_pkg::opened_t    cells_opened;
    logic [1:0]           status;

    modport source (output valid, tile_out, cells_opened, status, input ready);
    modport sink (input valid, tile_out, cells_opened, status, output ready);
endinterface
`default_nettype wire

>>> src/wenc_cfg_if.sv
// Configuration write channel interface of the wall erosion block.
`default_nettype none
interface wenc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/wall_erosion_neighbour_count_top.sv
// Top level of the wall erosion block: tile map, erosion sequencer and channels.
//
// Usage: requests arrive on req (write tile, read tile, run erosion), one
// result per request leaves on rsp, and registers are written on cfg, which
// is always ready. Writes answer straight from the idle state; reads first
// wait in S_RDWAIT for the registered tile read. A run walks the core of
// the map for each pass in two sweeps: a marking sweep that reads the center
// tile and, for walls, its eight neighbours, then an opening sweep that turns
// marked cells to floor. A skipped run or a map below three rows or columns
// answers straight from the idle state, without a sweep.
// The result sits in an output register; a new request is taken while the
// block is idle and that register is empty or being drained, so a stalled
// receiver holds the block after one finished result. Reset clears the
// control and configuration registers to their defaults; the tile map is
// undefined until written and the mark memory needs no clearing, since every
// marking sweep rewrites each core mark before the opening sweep reads it.
`default_nettype none
module wall_erosion_neighbour_count_top #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  wire          clk,
    input  wire          rst_n,
    wenc_req_if.sink     req,
    wenc_rsp_if.source   rsp,
    wenc_cfg_if.sink     cfg
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_P1_RD  = 3'd2;
    localparam logic [2:0] S_P1_EV  = 3'd3;
    localparam logic [2:0] S_P2_RD  = 3'd4;
    localparam logic [2:0] S_P2_EV  = 3'd5;

    // Configuration registers.
    logic [7:0] rows_cfg_reg, cols_cfg_reg;
    logic [3:0] passes_reg, bound_a_reg, bound_b_reg;

    // Control state.
    logic [2:0]  state_reg, state_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [3:0]  nb_reg, nb_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  pass_reg, pass_next;
    wenc_pkg::opened_t total_reg, total_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // Result payload.
    logic [7:0]        tile_out_reg;
    wenc_pkg::opened_t opened_reg;
    logic [1:0]        status_reg;
    logic              load_out;
    logic              load_from_mem;
    wenc_pkg::opened_t opened_in;
    logic [1:0]        status_in;

    // Memories and their ports.
    logic [7:0] tile_mem [DEPTH];
    logic       mark_mem [DEPTH];
    logic [7:0] tile_rd;
    logic       mark_rd;
    logic [AW-1:0] tile_ra, tile_wa, mark_wa;
    logic [7:0]    tile_wd;
    logic          tile_we, mark_we, mark_wd;

    // Map extent in use.
    logic [15:0] rows16, cols16, row16, col16;
    logic [RW:0] rlast;
    logic [CW:0] clast;
    logic [3:0]  lo, hi;
    logic        skip, tiny, out_range, req_fire, out_free;
    logic [AW-1:0] req_addr, cell_addr;

    // Neighbour address and core check.
    logic [RW-1:0] nrow;
    logic [CW-1:0] ncol;
    logic          ncore, hit, last_c, last_r;
    logic [3:0]    cnt_sum;

    assign rows16 = (16'(rows_cfg_reg) > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : 16'(rows_cfg_reg);
    assign cols16 = (16'(cols_cfg_reg) > 16'(MAX_COLS)) ? 16'(MAX_COLS) : 16'(cols_cfg_reg);
    assign rlast  = rows16[RW:0] - (RW+1)'(2);
    assign clast  = cols16[CW:0] - (CW+1)'(2);
    assign row16  = 16'(req.row);
    assign col16  = 16'(req.col);
    assign lo     = (bound_a_reg < bound_b_reg) ? bound_a_reg : bound_b_reg;
    assign hi     = (bound_a_reg < bound_b_reg) ? bound_b_reg : bound_a_reg;
    assign skip   = (passes_reg == 4'd0) || (lo <= 4'd1) || (hi > 4'd8);
    assign tiny   = (rows16 < 16'd3) || (cols16 < 16'd3);
    assign out_range = (row16 >= rows16) || (col16 >= cols16);
    assign req_addr  = {row16[RW-1:0], col16[CW-1:0]};
    assign cell_addr = {r_reg, c_reg};

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Neighbour selection: index 0 is the cell itself, 1..8 its Moore ring.
    always_comb
    begin
        nrow = r_reg;
        ncol = c_reg;
        unique case (nb_reg)
            4'd1:    begin nrow = r_reg - RW'(1); ncol = c_reg - CW'(1); end
            4'd2:    begin nrow = r_reg - RW'(1); end
            4'd3:    begin nrow = r_reg - RW'(1); ncol = c_reg + CW'(1); end
            4'd4:    begin ncol = c_reg - CW'(1); end
            4'd5:    begin ncol = c_reg + CW'(1); end
            4'd6:    begin nrow = r_reg + RW'(1); ncol = c_reg - CW'(1); end
            4'd7:    begin nrow = r_reg + RW'(1); end
            4'd8:    begin nrow = r_reg + RW'(1); ncol = c_reg + CW'(1); end
            default: begin end
        endcase
    end

    assign ncore = (nrow != '0) && ({1'b0, nrow} <= rlast)
                && (ncol != '0) && ({1'b0, ncol} <= clast);
    assign cnt_sum = cnt_reg + 4'((ncore && tile_rd == wenc_pkg::FLOOR_BYTE) ? 1 : 0);
    assign hit     = (cnt_sum >= lo) && (cnt_sum <= hi);
    assign last_c  = ({1'b0, c_reg} == clast);
    assign last_r  = ({1'b0, r_reg} == rlast);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg;
        c_next = c_reg;
        nb_next = nb_reg;
        cnt_next = cnt_reg;
        pass_next = pass_reg;
        total_next = total_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        load_out = 1'b0;
        load_from_mem = 1'b0;
        opened_in = '0;
        status_in = wenc_pkg::ST_DONE;
        tile_ra = req_addr;
        tile_we = 1'b0;
        tile_wa = req_addr;
        tile_wd = req.tile_in;
        mark_we = 1'b0;
        mark_wa = cell_addr;
        mark_wd = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    priority if (req.kind == wenc_pkg::KIND_WRITE || req.kind == wenc_pkg::KIND_READ)
                    begin
                        if (out_range)
                        begin
                            load_out = 1'b1;
                            status_in = wenc_pkg::ST_RANGE;
                        end
                        else if (req.kind == wenc_pkg::KIND_WRITE)
                        begin
                            tile_we = 1'b1;
                            load_out = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RDWAIT;
                        end
                    end
                    else if (req.kind == wenc_pkg::KIND_RUN)
                    begin
                        if (skip || tiny)
                        begin
                            load_out = 1'b1;
                            status_in = skip ? wenc_pkg::ST_SKIP : wenc_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = S_P1_RD;
                            r_next = RW'(1);
                            c_next = CW'(1);
                            nb_next = '0;
                            pass_next = '0;
                            total_next = '0;
                        end
                    end
                    else
                    begin
                        load_out = 1'b1;
                    end
                end
            end
            S_RDWAIT:
            begin
                load_out = 1'b1;
                load_from_mem = 1'b1;
                state_next = S_IDLE;
            end
            S_P1_RD:
            begin
                tile_ra = {nrow, ncol};
                state_next = S_P1_EV;
            end
            S_P1_EV:
            begin
                state_next = S_P1_RD;
                if (nb_reg == 4'd0 && tile_rd != wenc_pkg::WALL_BYTE)
                begin
                    // Not a wall: clear its mark and move on.
                    mark_we = 1'b1;
                    mark_wd = 1'b0;
                end
                else if (nb_reg == 4'd0)
                begin
                    nb_next = 4'd1;
                    cnt_next = '0;
                end
                else if (nb_reg != wenc_pkg::NB_LAST)
                begin
                    nb_next = nb_reg + 4'd1;
                    cnt_next = cnt_sum;
                end
                else
                begin
                    mark_we = 1'b1;
                    mark_wd = hit;
                end
                // Step to the next core cell once the mark is written.
                if (mark_we)
                begin
                    nb_next = '0;
                    if (!last_c)
                        c_next = c_reg + CW'(1);
                    else
                    begin
                        c_next = CW'(1);
                        if (!last_r)
                            r_next = r_reg + RW'(1);
                        else
                        begin
                            r_next = RW'(1);
                            state_next = S_P2_RD;
                        end
                    end
                end
            end
            S_P2_RD:
            begin
                state_next = S_P2_EV;
            end
            S_P2_EV:
            begin
                state_next = S_P2_RD;
                if (mark_rd)
                begin
                    tile_we = 1'b1;
                    tile_wa = cell_addr;
                    tile_wd = wenc_pkg::FLOOR_BYTE;
                    mark_we = 1'b1;
                    if (total_reg != wenc_pkg::OPENED_MAX)
                        total_next = total_reg + 15'd1;
                end
                if (!last_c)
                    c_next = c_reg + CW'(1);
                else
                begin
                    c_next = CW'(1);
                    if (!last_r)
                        r_next = r_reg + RW'(1);
                    else
                    begin
                        r_next = RW'(1);
                        pass_next = pass_reg + 4'd1;
                        if (pass_next == passes_reg)
                        begin
                            state_next = S_IDLE;
                            load_out = 1'b1;
                            opened_in = total_next;
                        end
                        else
                            state_next = S_P1_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            rsp_valid_next = 1'b1;
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            nb_reg        <= '0;
            cnt_reg       <= '0;
            pass_reg      <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rows_cfg_reg  <= 8'd128;
            cols_cfg_reg  <= 8'd128;
            passes_reg    <= 4'd1;
            bound_a_reg   <= 4'd2;
            bound_b_reg   <= 4'd8;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            nb_reg        <= nb_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    wenc_pkg::CFG_ROWS:    rows_cfg_reg <= cfg.data;
                    wenc_pkg::CFG_COLS:    cols_cfg_reg <= cfg.data;
                    wenc_pkg::CFG_PASSES:  passes_reg   <= cfg.data[3:0];
                    wenc_pkg::CFG_BOUND_A: bound_a_reg  <= cfg.data[3:0];
                    wenc_pkg::CFG_BOUND_B: bound_b_reg  <= cfg.data[3:0];
                    default: begin end
                endcase
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            tile_out_reg <= load_from_mem ? tile_rd : 8'd0;
            opened_reg   <= opened_in;
            status_reg   <= status_in;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.tile_out     = tile_out_reg;
    assign rsp.cells_opened = opened_reg;
    assign rsp.status       = status_reg;

    // Tile memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (tile_we)
            tile_mem[tile_wa] <= tile_wd;
        tile_rd <= tile_mem[tile_ra];
    end

    // Mark memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        mark_rd <= mark_mem[cell_addr];
    end

    // An accepted request leaves the block busy or with a result pending.
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (rsp_valid_reg || state_reg != S_IDLE))
        else $error("request accepted without progress");

    // The neighbour index never runs past the ring.
    a_nb_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P1_RD || state_reg == S_P1_EV) |-> (nb_reg <= wenc_pkg::NB_LAST))
        else $error("neighbour index out of range");

    // The sweeps stay off the border row and column.
    a_core_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P1_EV || state_reg == S_P2_EV) |-> (r_reg != '0 && c_reg != '0))
        else $error("sweep on border");

    // A skipped run opens nothing.
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == wenc_pkg::ST_SKIP) |-> (opened_reg == '0))
        else $error("skipped run reports openings");

endmodule
`default_nettype wire

>>> verif/wall_erosion_neighbour_count_top_tb.sv
// Testbench of the wall erosion block: tile map traffic, erosion runs and checks.
`timescale 1ns / 100ps

// One result as the block should report it.
typedef struct {
    logic [7:0]        tile;
    wenc_pkg::opened_t opened;
    logic [1:0]        status;
} tile_result_t;

// Tracks the tile map and register state, and holds the expected results.
class erosion_scoreboard;
    localparam int MAP_DIM = 128;
    localparam int MAP_CELLS = MAP_DIM * MAP_DIM;

    logic [7:0]   tiles [MAP_CELLS];
    bit           written [MAP_CELLS];
    int unsigned  rows_reg;
    int unsigned  cols_reg;
    int unsigned  passes_reg;
    int unsigned  bound_a;
    int unsigned  bound_b;
    tile_result_t expected_results [$];
    int           errors;

    function new();
        foreach (tiles[i])
        begin
            tiles[i] = 8'h00;
            written[i] = 1'b0;
        end
        rows_reg = 128;
        cols_reg = 128;
        passes_reg = 1;
        bound_a = 2;
        bound_b = 8;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] data);
        case (idx)
            wenc_pkg::CFG_ROWS:    rows_reg = data;
            wenc_pkg::CFG_COLS:    cols_reg = data;
            wenc_pkg::CFG_PASSES:  passes_reg = data[3:0];
            wenc_pkg::CFG_BOUND_A: bound_a = data[3:0];
            wenc_pkg::CFG_BOUND_B: bound_b = data[3:0];
            default:     ;
        endcase
    endfunction

    function int rows_in_use();
        return (rows_reg > MAP_DIM) ? MAP_DIM : rows_reg;
    endfunction

    function int cols_in_use();
        return (cols_reg > MAP_DIM) ? MAP_DIM : cols_reg;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // Floor neighbours of a cell that lie strictly inside the border ring.
    function int floor_around(int r, int c, int nr, int nc);
        int n;
        int rr;
        int cc;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = r + dr;
                cc = c + dc;
                if ((dr != 0 || dc != 0) && rr >= 1 && rr < nr - 1 && cc >= 1 && cc < nc - 1)
                begin
                    if (tiles[rr * MAP_DIM + cc] == wenc_pkg::FLOOR_BYTE)
                        n++;
                end
            end
        end
        return n;
    endfunction

    // Erosion passes; every mark of a pass is applied after the whole sweep.
    function void erode(ref tile_result_t res);
        int unsigned lo;
        int unsigned hi;
        int nr;
        int nc;
        int n;
        int to_open [$];
        lo = (bound_a < bound_b) ? bound_a : bound_b;
        hi = (bound_a < bound_b) ? bound_b : bound_a;
        nr = rows_in_use();
        nc = cols_in_use();
        if (passes_reg == 0 || lo <= 1 || hi > 8)
        begin
            res.status = wenc_pkg::ST_SKIP;
            return;
        end
        for (int p = 0; p < passes_reg; p++)
        begin
            to_open.delete();
            for (int r = 1; r < nr - 1; r++)
            begin
                for (int c = 1; c < nc - 1; c++)
                begin
                    if (tiles[r * MAP_DIM + c] == wenc_pkg::WALL_BYTE)
                    begin
                        n = floor_around(r, c, nr, nc);
                        if (n >= lo && n <= hi)
                            to_open = {to_open, r * MAP_DIM + c};
                    end
                end
            end
            foreach (to_open[i])
            begin
                tiles[to_open[i]] = wenc_pkg::FLOOR_BYTE;
                if (res.opened != wenc_pkg::OPENED_MAX)
                    res.opened = res.opened + 1'b1;
            end
        end
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(logic [1:0] kind, logic [6:0] r, logic [6:0] c,
                               logic [7:0] t);
        tile_result_t res;
        int k;
        res.tile = 8'h00;
        res.opened = '0;
        res.status = wenc_pkg::ST_DONE;
        k = r * MAP_DIM + c;
        if (kind == wenc_pkg::KIND_WRITE || kind == wenc_pkg::KIND_READ)
        begin
            if (r >= rows_in_use() || c >= cols_in_use())
                res.status = wenc_pkg::ST_RANGE;
            else if (kind == wenc_pkg::KIND_WRITE)
            begin
                tiles[k] = t;
                written[k] = 1'b1;
            end
            else
                res.tile = tiles[k];
        end
        else if (kind == wenc_pkg::KIND_RUN)
            erode(res);
        expected_results = {expected_results, res};
    endfunction

    // Compares a delivered result with the oldest expectation.
    function void check_result(logic [7:0] tile, wenc_pkg::opened_t opened,
                               logic [1:0] status);
        tile_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with no request outstanding: tile_out %0d cells_opened %0d status %0d",
                   tile, opened, status);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (tile !== want.tile)
        begin
            $error("tile_out: expected %0d, actual %0d", want.tile, tile);
            errors++;
        end
        if (opened !== want.opened)
        begin
            $error("cells_opened: expected %0d, actual %0d", want.opened, opened);
            errors++;
        end
        if (status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
        end
    endfunction
endclass

module wall_erosion_neighbour_count_top_tb;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_TARGET = 1700;
    localparam logic [1:0] KIND_NONE = 2'd3;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   hold_req;
    int   hold_seen;
    int   hold_left;
    int   items_sent;
    longint cycles;

    erosion_scoreboard sb;

    wenc_req_if req_ch();
    wenc_rsp_if rsp_ch();
    wenc_cfg_if cfg_ch();

    wall_erosion_neighbour_count_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: results are checked before the request of the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.tile_out, rsp_ch.cells_opened, rsp_ch.status);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.kind, req_ch.row, req_ch.col, req_ch.tile_in);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly walls and floor, with an occasional arbitrary byte.
    function automatic logic [7:0] random_tile();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return wenc_pkg::WALL_BYTE;
        else if (sel < 90)
            return wenc_pkg::FLOOR_BYTE;
        return 8'($urandom_range(255));
    endfunction

    // Offers one request, with random idle cycles in front of it.
    task automatic send_item(input logic [1:0] kind, input int r, input int c,
                             input logic [7:0] t);
        if ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.row <= r[6:0];
        req_ch.col <= c[6:0];
        req_ch.tile_in <= t;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // Holds the sender until every expected result has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int rows, input int cols, input int passes,
                              input int a, input int b);
        cfg_write(wenc_pkg::CFG_ROWS, rows[7:0]);
        cfg_write(wenc_pkg::CFG_COLS, cols[7:0]);
        cfg_write(wenc_pkg::CFG_PASSES, passes[7:0]);
        cfg_write(wenc_pkg::CFG_BOUND_A, a[7:0]);
        cfg_write(wenc_pkg::CFG_BOUND_B, b[7:0]);
    endtask

    // Fills the core of the map, then mixes reads, writes, runs and noise.
    task automatic run_phase(input int count);
        int nr;
        int nc;
        int sel;
        int r;
        int c;
        logic [1:0] kind;
        nr = sb.rows_in_use();
        nc = sb.cols_in_use();
        for (int rr = 1; rr < nr - 1; rr++)
            for (int cc = 1; cc < nc - 1; cc++)
                send_item(wenc_pkg::KIND_WRITE, rr, cc, random_tile());
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 65 && nr > 0 && nc > 0)
            begin
                r = $urandom_range(nr - 1);
                c = $urandom_range(nc - 1);
                kind = (sel < 35 && sb.written[r * 128 + c]) ? wenc_pkg::KIND_READ
                                                              : wenc_pkg::KIND_WRITE;
                send_item(kind, r, c, random_tile());
            end
            else if (sel < 78)
            begin
                // Any position, often outside the map in use.
                r = $urandom_range(127);
                c = $urandom_range(127);
                kind = 2'($urandom_range(1));
                if (kind == wenc_pkg::KIND_READ && r < nr && c < nc
                    && !sb.written[r * 128 + c])
                    kind = wenc_pkg::KIND_WRITE;
                send_item(kind, r, c, 8'($urandom_range(255)));
            end
            else if (sel < 91)
                send_item(wenc_pkg::KIND_RUN, $urandom_range(127), $urandom_range(127),
                          8'($urandom_range(255)));
            else
                send_item(KIND_NONE, $urandom_range(127), $urandom_range(127),
                          8'($urandom_range(255)));
        end
        drain();
    endtask

    // Stimulus: directed corners first, then random phases.
    initial
    begin
        int phase;
        int lo_b;
        sb = new();
        cycles = 0;
        items_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = wenc_pkg::KIND_WRITE;
        req_ch.row = '0;
        req_ch.col = '0;
        req_ch.tile_in = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = wenc_pkg::CFG_ROWS;
        cfg_ch.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: corners of the full map and the unused kind.
        send_item(wenc_pkg::KIND_WRITE, 0, 0, 8'h00);
        send_item(wenc_pkg::KIND_WRITE, 127, 127, 8'hFF);
        send_item(wenc_pkg::KIND_WRITE, 127, 0, wenc_pkg::WALL_BYTE);
        send_item(wenc_pkg::KIND_READ, 127, 127, 8'h00);
        send_item(wenc_pkg::KIND_READ, 0, 0, 8'hFF);
        send_item(wenc_pkg::KIND_READ, 127, 0, 8'h00);
        send_item(KIND_NONE, 127, 127, 8'hFF);
        send_item(KIND_NONE, 0, 0, 8'h00);
        drain();

        // Saturated row count, narrow map, fifteen passes, swapped bounds.
        set_config(255, 3, 15, 8, 2);
        run_phase(8);
        // Three rows across the full width.
        idle_pct = 59;
        set_config(3, 128, 1, 2, 8);
        run_phase(8);
        // Map too small to have a core.
        idle_pct = 0;
        stall_pct = 59;
        set_config(2, 9, 3, 3, 5);
        run_phase(6);
        set_config(0, 0, 3, 3, 5);
        run_phase(4);
        // Skipped runs: no passes, low bound of one, high bound above eight.
        idle_pct = 14;
        stall_pct = 14;
        set_config(6, 6, 0, 3, 5);
        run_phase(4);
        set_config(6, 6, 2, 1, 6);
        run_phase(4);
        set_config(6, 6, 2, 9, 3);
        run_phase(4);
        set_config(5, 7, 2, 15, 4);
        run_phase(4);

        // Random phases, cycling through the idling patterns.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 59; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 59; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            lo_b = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 5);
            if ($urandom_range(11) == 0)
                set_config($urandom_range(2), $urandom_range(3, 9), $urandom_range(1, 4),
                           lo_b, $urandom_range(8));
            else
                set_config($urandom_range(3, 9), $urandom_range(3, 9), $urandom_range(4),
                           lo_b, $urandom_range(lo_b, 9));
            if (phase == 2)
            begin
                // Long receiver hold-off while requests keep coming.
                hold_req++;
                for (int i = 0; i < 30; i++)
                    send_item(wenc_pkg::KIND_WRITE, 0, 0, 8'($urandom_range(255)));
            end
            run_phase(90);
            phase++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
